/* src/tcw_pkg.sv */
// Shared types and constants for the text console writer.
// Holds kind codes, cell constants and the controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int TCW_COLS = 80;
    localparam int TCW_ROWS = 25;

    localparam int CELL_W = 16;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] ATTR_BLANK   = 8'h0F;
    localparam logic [CELL_W-1:0] CELL_BLANK = {ATTR_BLANK, CHAR_SPACE};

    localparam logic [1:0] KIND_PRINT = 2'd0;
    localparam logic [1:0] KIND_PLACE = 2'd1;
    localparam logic [1:0] KIND_SETCUR = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic capture;     // latch the accepted beat
        logic exec;        // carry out the held item
        logic rd_capture;  // take the cell read from the screen store
        logic clr_wr;      // blank one cell of the reset sweep
        logic scr_wr;      // blank one cell of the scrolled-in row
        logic base_adv;    // advance the top-row pointer
        logic load_out;    // load the output register
    } t_tcw_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;    // sweep counter on the last cell of the screen
        logic row_last;    // sweep counter on the last column
        logic need_read;   // held item is an in-range cell read
        logic need_scroll; // held item scrolls the screen
    } t_tcw_sts;

endpackage

/* src/tcw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Width and depth are parameters; no dependencies.
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/tcw_ctrl.sv */
// Sequencing controller for the text console writer.
// Depends on tcw_pkg for the command and status structs.
`timescale 1ns / 1ps

module tcw_ctrl import tcw_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_tcw_sts i_sts,
    output t_tcw_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SCROLL,
        S_PUSH
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_CLEAR:  o_cmd.clr_wr = 1'b1;
            S_IDLE:   o_cmd.capture = i_in_valid;
            S_EXEC:   o_cmd.exec = 1'b1;
            S_READ:   o_cmd.rd_capture = 1'b1;
            S_SCROLL: begin
                o_cmd.scr_wr   = 1'b1;
                o_cmd.base_adv = i_sts.row_last;
            end
            S_PUSH:   o_cmd.load_out = out_free;
            default:  o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (i_sts.clr_last) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (i_sts.need_read) begin
                        r_state <= S_READ;
                    end else if (i_sts.need_scroll) begin
                        r_state <= S_SCROLL;
                    end else begin
                        r_state <= S_PUSH;
                    end
                end
                S_READ:   r_state <= S_PUSH;
                S_SCROLL: begin
                    if (i_sts.row_last) r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (out_free) r_state <= S_IDLE;
                end
                default:  r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* src/tcw_dp.sv */
// Datapath for the text console writer: cursor, top-row pointer, sweep counter,
// address mapping, screen store and output register. Depends on tcw_pkg, tcw_ram.
`timescale 1ns / 1ps

module tcw_dp import tcw_pkg::*; #(
    parameter int COLS = TCW_COLS,
    parameter int ROWS = TCW_ROWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_tcw_cmd    i_cmd,
    output t_tcw_sts    o_sts,
    input  logic [1:0]  i_kind,
    input  logic [6:0]  i_col,
    input  logic [4:0]  i_row,
    input  logic [7:0]  i_char_code,
    input  logic [7:0]  i_attrib,
    input  logic        i_text_end,
    output logic [6:0]  o_cursor_col,
    output logic [4:0]  o_cursor_row,
    output logic [10:0] o_shown_cursor,
    output logic [7:0]  o_cell_char,
    output logic [7:0]  o_cell_attrib,
    output logic        o_scrolled
);

    localparam int CW    = $clog2(COLS);
    localparam int RW    = $clog2(ROWS);
    localparam int TOTAL = COLS * ROWS;
    localparam int AW    = $clog2(TOTAL);

    localparam logic [AW-1:0] COLS_A     = AW'(COLS);
    localparam logic [AW-1:0] LAST_CELL  = AW'(TOTAL - 1);
    localparam logic [AW-1:0] LAST_COL_A = AW'(COLS - 1);
    localparam logic [CW-1:0] LAST_COL   = CW'(COLS - 1);
    localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
    localparam logic [7:0]    COLS_8     = 8'(COLS);
    localparam logic [6:0]    ROWS_7     = 7'(ROWS);

    // held item
    logic [1:0]  r_kind;
    logic [6:0]  r_col;
    logic [4:0]  r_row;
    logic [7:0]  r_char;
    logic [7:0]  r_attr;
    logic        r_tend;

    // cursor and screen geometry
    logic [CW-1:0] r_work_col;
    logic [RW-1:0] r_work_row;
    logic [10:0]   r_shown;
    logic [RW-1:0] r_base;
    logic [AW-1:0] r_cnt;

    // pending result fields
    logic [7:0] r_res_char;
    logic [7:0] r_res_attr;
    logic       r_res_scr;

    // output register
    logic [6:0]  r_o_col;
    logic [4:0]  r_o_row;
    logic [10:0] r_o_shown;
    logic [7:0]  r_o_char;
    logic [7:0]  r_o_attr;
    logic        r_o_scr;

    logic          in_range;
    logic          is_nl;
    logic          wrap;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;
    logic          scroll;
    logic [6:0]    row_ext;
    logic [RW-1:0] item_row;
    logic [CW-1:0] item_col;
    logic [AW-1:0] item_addr;
    logic [AW-1:0] work_addr;
    logic [AW-1:0] base_addr;
    logic [AW-1:0] set_lin;
    logic [AW-1:0] next_lin;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [CELL_W-1:0] ram_rdata;

    // Logical row to physical address: rows rotate around the top-row pointer.
    function automatic logic [AW-1:0] map_addr(input logic [RW-1:0] lrow,
                                               input logic [CW-1:0] lcol,
                                               input logic [RW-1:0] base);
        logic [RW:0]   sum;
        logic [RW-1:0] prow;
        logic [AW-1:0] prod;
        sum = {1'b0, lrow} + {1'b0, base};
        if (sum >= (RW+1)'(ROWS)) begin
            sum = sum - (RW+1)'(ROWS);
        end
        prow = sum[RW-1:0];
        prod = AW'(prow) * COLS_A;
        return prod + AW'(lcol);
    endfunction

    assign in_range = ({1'b0, r_col} < COLS_8) && ({2'b00, r_row} < ROWS_7);
    assign is_nl    = (r_char == CHAR_NEWLINE);
    assign row_ext  = 7'(r_row);
    assign item_row = row_ext[RW-1:0];
    assign item_col = r_col[CW-1:0];

    assign item_addr = map_addr(item_row, item_col, r_base);
    assign work_addr = map_addr(r_work_row, r_work_col, r_base);
    assign base_addr = AW'(r_base) * COLS_A;
    assign set_lin   = AW'(item_row) * COLS_A + AW'(item_col);

    // Cursor advance for a printed character.
    always_comb begin
        wrap = is_nl || (r_work_col == LAST_COL);
        n_col = wrap ? '0 : r_work_col + 1'b1;
        scroll = wrap && (r_work_row == LAST_ROW);
        if (!wrap || scroll) begin
            n_row = r_work_row;
        end else begin
            n_row = r_work_row + 1'b1;
        end
        next_lin = AW'(n_row) * COLS_A + AW'(n_col);
    end

    assign o_sts.clr_last    = (r_cnt == LAST_CELL);
    assign o_sts.row_last    = (r_cnt == LAST_COL_A);
    assign o_sts.need_read   = (r_kind == KIND_READ) && in_range;
    assign o_sts.need_scroll = (r_kind == KIND_PRINT) && scroll;

    // Write port: reset sweep, scroll blanking, then item writes.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cnt;
        ram_wdata = CELL_BLANK;
        if (i_cmd.clr_wr) begin
            ram_we = 1'b1;
        end else if (i_cmd.scr_wr) begin
            ram_we    = 1'b1;
            ram_waddr = base_addr + r_cnt;
        end else if (i_cmd.exec) begin
            ram_wdata = {r_attr, r_char};
            if (r_kind == KIND_PRINT && !is_nl) begin
                ram_we    = 1'b1;
                ram_waddr = work_addr;
            end else if (r_kind == KIND_PLACE && in_range) begin
                ram_we    = 1'b1;
                ram_waddr = item_addr;
            end
        end
    end

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (TOTAL)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (item_addr),
        .o_rdata (ram_rdata)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work_col <= '0;
            r_work_row <= '0;
            r_shown    <= '0;
            r_base     <= '0;
            r_cnt      <= '0;
        end else begin
            if ((i_cmd.clr_wr && o_sts.clr_last) || (i_cmd.scr_wr && o_sts.row_last)) begin
                r_cnt <= '0;
            end else if (i_cmd.clr_wr || i_cmd.scr_wr) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.base_adv) begin
                r_base <= (r_base == LAST_ROW) ? '0 : r_base + 1'b1;
            end
            if (i_cmd.exec) begin
                case (r_kind)
                    KIND_PRINT: begin
                        r_work_col <= n_col;
                        r_work_row <= n_row;
                        if (r_tend) r_shown <= 11'(next_lin);
                    end
                    KIND_SETCUR: begin
                        if (in_range) begin
                            r_work_col <= item_col;
                            r_work_row <= item_row;
                            r_shown    <= 11'(set_lin);
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_kind;
            r_col  <= i_col;
            r_row  <= i_row;
            r_char <= i_char_code;
            r_attr <= i_attrib;
            r_tend <= i_text_end;
        end
        if (i_cmd.exec) begin
            r_res_char <= '0;
            r_res_attr <= '0;
            r_res_scr  <= (r_kind == KIND_PRINT) && scroll;
        end else if (i_cmd.rd_capture) begin
            r_res_char <= ram_rdata[7:0];
            r_res_attr <= ram_rdata[15:8];
        end
        if (i_cmd.load_out) begin
            r_o_col   <= 7'(r_work_col);
            r_o_row   <= 5'(r_work_row);
            r_o_shown <= r_shown;
            r_o_char  <= r_res_char;
            r_o_attr  <= r_res_attr;
            r_o_scr   <= r_res_scr;
        end
    end

    assign o_cursor_col   = r_o_col;
    assign o_cursor_row   = r_o_row;
    assign o_shown_cursor = r_o_shown;
    assign o_cell_char    = r_o_char;
    assign o_cell_attrib  = r_o_attr;
    assign o_scrolled     = r_o_scr;

endmodule

/* src/text_console_writer_top.sv */
// Text console writer: top level joining the controller and the datapath.
// Depends on tcw_pkg, tcw_ctrl, tcw_dp (which holds tcw_ram).
//
// Use: a COLS x ROWS text screen store with a working cursor and a shown cursor.
// Each input beat on the s_axis channel carries one command; tuser gives its
// kind (print at cursor, place cell, set cursor, read cell), tlast marks the
// last printed character of a text and commits the shown cursor. Every input
// beat yields exactly one m_axis beat with the cursor after the command, the
// shown cursor, the cell read (zero unless a read) and a scroll flag.
// Timing: an ordinary beat passes through capture, execute and loading of the
// output register before the next can be accepted. A cell read adds a state
// for the registered store read. A print that scrolls adds a sweep that blanks
// the cells of the new bottom row in turn; scrolling itself only rotates the
// top-row pointer, so no rows are copied. The store's single write port and
// single read port set this sequence.
// Reset: all cursors go to zero, then a sweep of the COLS*ROWS cells (2000 at
// the default size) blanks the screen to space on attribute 0x0F; s_axis_tready
// stays low for that sweep.
// Stall: the output register holds its beat while m_axis_tready is low; one
// further input beat is still taken and worked, then waits for the slot.
`timescale 1ns / 1ps

module text_console_writer_top import tcw_pkg::*; #(
    parameter int COLS = TCW_COLS,
    parameter int ROWS = TCW_ROWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // col[6:0], row[11:7], char_code[19:12], attrib[27:20], zero pad[31:28]
    input  logic [31:0] s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]  s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // cursor_col[6:0], cursor_row[11:7], shown_cursor[22:12],
    // cell_char[30:23], cell_attrib[38:31], scrolled[39]
    output logic [39:0] m_axis_tdata
);

    t_tcw_cmd cmd;
    t_tcw_sts sts;

    logic [6:0]  cur_col;
    logic [4:0]  cur_row;
    logic [10:0] shown;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attrib;
    logic        scrolled;

    // Sequencing: sweep, accept, execute, optional read or scroll, push.
    tcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Cursor, screen store and output register.
    tcw_dp #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_kind         (s_axis_tuser),
        .i_col          (s_axis_tdata[6:0]),
        .i_row          (s_axis_tdata[11:7]),
        .i_char_code    (s_axis_tdata[19:12]),
        .i_attrib       (s_axis_tdata[27:20]),
        .i_text_end     (s_axis_tlast),
        .o_cursor_col   (cur_col),
        .o_cursor_row   (cur_row),
        .o_shown_cursor (shown),
        .o_cell_char    (cell_char),
        .o_cell_attrib  (cell_attrib),
        .o_scrolled     (scrolled)
    );

    // Pack the result beat, first field in the lowest bits.
    assign m_axis_tdata = {scrolled, cell_attrib, cell_char, shown, cur_row, cur_col};

endmodule
